// ===== hw/rtl/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types and constants of the partial permutation generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int DEF_MAX_POOL    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int CFG_W       = 5;
    localparam int MODE_W      = 2;
    localparam int ELEM_IDX_W  = 4;
    localparam int ELEM_VAL_W  = 32;
    localparam int POS_W       = 4;
    localparam int PIDX_W      = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_BEGIN   = 2'd1,
        MODE_ADVANCE = 2'd2
    } t_mode;

    typedef enum logic [0:0] {
        REG_POOL_SIZE = 1'b0,
        REG_TUPLE_LEN = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BEGIN,
        S_INIT,
        S_ADV_RD,
        S_ADV_CHK,
        S_SWAP_WR1,
        S_SWAP_WR2,
        S_ROT_RD,
        S_ROT_WR,
        S_ROT_END,
        S_EMIT_IDX,
        S_EMIT_VAL,
        S_EMIT_OUT,
        S_EMPTY,
        S_EXH
    } t_state;

    typedef struct packed {
        logic load_write;
        logic latch;
        logic set_finished;
        logic adv_start;
        logic init_step;
        logic rd_pos;
        logic chk;
        logic sw1;
        logic sw2;
        logic rot_rd;
        logic rot_wr;
        logic rot_fin;
        logic pos_dec;
        logic emit_start;
        logic emit_idx;
        logic emit_val;
        logic emit_out;
        logic emit_empty;
        logic emit_exh;
    } t_cmd;

    typedef struct packed {
        logic finished;
        logic r_zero;
        logic dec_zero;
        logic m_end;
        logic i_zero;
        logic init_last;
        logic k_last;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/ppg_ram.sv =====
// ----------------------------------------------------------------------------
// ppg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/ppg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppg_ctrl
// Sequencer for begin, advance (counter walk, swap, rotate) and emission.
// ----------------------------------------------------------------------------
module ppg_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [ppg_pkg::MODE_W-1:0]  i_mode,
    input  ppg_pkg::t_status            i_status,
    output logic                        o_in_ready,
    output ppg_pkg::t_cmd               o_cmd
);

    import ppg_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MODE_BEGIN: n_state = S_BEGIN;
                        MODE_ADVANCE: begin
                            if (i_status.finished || i_status.r_zero) begin
                                n_state = S_EXH;
                            end else begin
                                n_state = S_ADV_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_BEGIN: begin
                if (i_status.finished) begin
                    n_state = S_EXH;
                end else if (i_status.r_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (i_status.init_last) begin
                    n_state = S_EMIT_IDX;
                end
            end
            S_ADV_RD:   n_state = S_ADV_CHK;
            S_ADV_CHK: begin
                if (i_status.dec_zero) begin
                    n_state = S_ROT_RD;
                end else begin
                    n_state = S_SWAP_WR1;
                end
            end
            S_SWAP_WR1: n_state = S_SWAP_WR2;
            S_SWAP_WR2: n_state = S_EMIT_IDX;
            S_ROT_RD: begin
                if (i_status.m_end) begin
                    n_state = S_ROT_END;
                end else begin
                    n_state = S_ROT_WR;
                end
            end
            S_ROT_WR:   n_state = S_ROT_RD;
            S_ROT_END: begin
                if (i_status.i_zero) begin
                    n_state = S_EXH;
                end else begin
                    n_state = S_ADV_RD;
                end
            end
            S_EMIT_IDX: n_state = S_EMIT_VAL;
            S_EMIT_VAL: n_state = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.k_last ? S_IDLE : S_EMIT_IDX;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EXH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MODE_LOAD:  o_cmd.load_write = 1'b1;
                        MODE_BEGIN: o_cmd.latch      = 1'b1;
                        MODE_ADVANCE: begin
                            if (!i_status.finished) begin
                                if (i_status.r_zero) begin
                                    o_cmd.set_finished = 1'b1;
                                end else begin
                                    o_cmd.adv_start = 1'b1;
                                end
                            end
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_step  = 1'b1;
                o_cmd.emit_start = i_status.init_last;
            end
            S_ADV_RD:   o_cmd.rd_pos = 1'b1;
            S_ADV_CHK:  o_cmd.chk    = 1'b1;
            S_SWAP_WR1: o_cmd.sw1    = 1'b1;
            S_SWAP_WR2: begin
                o_cmd.sw2        = 1'b1;
                o_cmd.emit_start = 1'b1;
            end
            S_ROT_RD:   o_cmd.rot_rd = !i_status.m_end;
            S_ROT_WR:   o_cmd.rot_wr = 1'b1;
            S_ROT_END: begin
                o_cmd.rot_fin      = 1'b1;
                o_cmd.set_finished = i_status.i_zero;
                o_cmd.pos_dec      = !i_status.i_zero;
            end
            S_EMIT_IDX: o_cmd.emit_idx   = 1'b1;
            S_EMIT_VAL: o_cmd.emit_val   = 1'b1;
            S_EMIT_OUT: o_cmd.emit_out   = i_status.out_free;
            S_EMPTY:    o_cmd.emit_empty = i_status.out_free;
            S_EXH:      o_cmd.emit_exh   = i_status.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/ppg_dp.sv =====
// ----------------------------------------------------------------------------
// ppg_dp
// Datapath: pool, index and counter RAMs, run registers and output register.
// ----------------------------------------------------------------------------
module ppg_dp #(
    parameter int MAX_POOL    = ppg_pkg::DEF_MAX_POOL,
    parameter int VALUE_WIDTH = ppg_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppg_pkg::t_cmd                   i_cmd,
    input  logic [ppg_pkg::ELEM_IDX_W-1:0]  i_elem_index,
    input  logic [ppg_pkg::ELEM_VAL_W-1:0]  i_elem_value,
    input  logic [ppg_pkg::CFG_W-1:0]       i_cfg_pool_size,
    input  logic [ppg_pkg::CFG_W-1:0]       i_cfg_tuple_len,
    input  logic                            i_out_ready,
    output ppg_pkg::t_status                o_status,
    output logic                            o_out_valid,
    output logic [ppg_pkg::POS_W-1:0]       o_position,
    output logic [ppg_pkg::ELEM_VAL_W-1:0]  o_value,
    output logic [ppg_pkg::PIDX_W-1:0]      o_pool_index,
    output logic                            o_last,
    output logic                            o_exhausted,
    output logic                            o_empty_tuple
);

    import ppg_pkg::*;

    localparam int IW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CW = $clog2(MAX_POOL + 1);

    logic [CW-1:0]          r_run_n;
    logic [CW-1:0]          r_run_r;
    logic                   r_finished;
    logic [IW-1:0]          r_pos;
    logic [IW-1:0]          r_m;
    logic [IW-1:0]          r_k;
    logic [IW-1:0]          r_first;
    logic [IW-1:0]          r_other;

    logic                   r_out_valid;
    logic [POS_W-1:0]       r_out_pos;
    logic [ELEM_VAL_W-1:0]  r_out_val;
    logic [PIDX_W-1:0]      r_out_pidx;
    logic                   r_out_last;
    logic                   r_out_exh;
    logic                   r_out_empty;

    logic                   idx_we;
    logic [IW-1:0]          idx_waddr;
    logic [IW-1:0]          idx_wdata;
    logic                   idx_re;
    logic [IW-1:0]          idx_raddr;
    logic [IW-1:0]          idx_rd;

    logic                   cnt_we;
    logic [IW-1:0]          cnt_waddr;
    logic [CW-1:0]          cnt_wdata;
    logic                   cnt_re;
    logic [CW-1:0]          cnt_rd;

    logic                   pool_we;
    logic [VALUE_WIDTH-1:0] pool_rd;

    logic [CW-1:0]          cnt_dec;
    logic [IW-1:0]          other_c;
    logic [CW-1:0]          n_sat;
    logic                   n_finished;
    logic                   out_free;

    assign cnt_dec  = cnt_rd - CW'(1);
    assign other_c  = IW'(r_run_n - cnt_dec);
    assign out_free = !r_out_valid || i_out_ready;
    assign pool_we  = i_cmd.load_write && (int'(i_elem_index) < MAX_POOL);

    always_comb begin
        if (int'(i_cfg_pool_size) > MAX_POOL) begin
            n_sat = CW'(MAX_POOL);
        end else begin
            n_sat = CW'(i_cfg_pool_size);
        end
        n_finished = int'(i_cfg_tuple_len) > int'(n_sat);
    end

    // ram port steering
    always_comb begin
        idx_we    = 1'b0;
        idx_waddr = r_pos;
        idx_wdata = idx_rd;
        idx_re    = 1'b0;
        idx_raddr = r_pos;
        cnt_we    = 1'b0;
        cnt_waddr = r_pos;
        cnt_wdata = cnt_dec;
        cnt_re    = 1'b0;
        if (i_cmd.init_step) begin
            idx_we    = 1'b1;
            idx_waddr = r_k;
            idx_wdata = r_k;
            cnt_we    = 1'b1;
            cnt_waddr = r_k;
            cnt_wdata = r_run_n - CW'(r_k);
        end
        if (i_cmd.rd_pos) begin
            idx_re = 1'b1;
            cnt_re = 1'b1;
        end
        if (i_cmd.chk) begin
            cnt_we = 1'b1;
            if (cnt_dec == '0) begin
                cnt_wdata = r_run_n - CW'(r_pos);
            end else begin
                idx_re    = 1'b1;
                idx_raddr = other_c;
            end
        end
        if (i_cmd.sw1) begin
            idx_we = 1'b1;
        end
        if (i_cmd.sw2) begin
            idx_we    = 1'b1;
            idx_waddr = r_other;
            idx_wdata = r_first;
        end
        if (i_cmd.rot_rd) begin
            idx_re    = 1'b1;
            idx_raddr = r_m + IW'(1);
        end
        if (i_cmd.rot_wr) begin
            idx_we    = 1'b1;
            idx_waddr = r_m;
        end
        if (i_cmd.rot_fin) begin
            idx_we    = 1'b1;
            idx_waddr = IW'(r_run_n - CW'(1));
            idx_wdata = r_first;
        end
        if (i_cmd.emit_idx) begin
            idx_re    = 1'b1;
            idx_raddr = r_k;
        end
    end

    ppg_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_POOL)
    ) u_pool_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pool_we),
        .i_wr_addr (IW'(i_elem_index)),
        .i_wr_data (VALUE_WIDTH'(i_elem_value)),
        .i_rd_en   (i_cmd.emit_val),
        .i_rd_addr (idx_rd),
        .o_rd_data (pool_rd)
    );

    ppg_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_POOL)
    ) u_idx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (idx_we),
        .i_wr_addr (idx_waddr),
        .i_wr_data (idx_wdata),
        .i_rd_en   (idx_re),
        .i_rd_addr (idx_raddr),
        .o_rd_data (idx_rd)
    );

    ppg_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_POOL)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (cnt_waddr),
        .i_wr_data (cnt_wdata),
        .i_rd_en   (cnt_re),
        .i_rd_addr (r_pos),
        .o_rd_data (cnt_rd)
    );

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_n    <= '0;
            r_run_r    <= '0;
            r_finished <= 1'b1;
            r_pos      <= '0;
            r_m        <= '0;
            r_k        <= '0;
            r_first    <= '0;
            r_other    <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_run_n    <= n_sat;
                r_run_r    <= CW'(i_cfg_tuple_len);
                r_finished <= n_finished;
                r_k        <= '0;
            end
            if (i_cmd.set_finished) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.adv_start) begin
                r_pos <= IW'(r_run_r - CW'(1));
            end
            if (i_cmd.chk) begin
                r_first <= idx_rd;
                r_other <= other_c;
                r_m     <= r_pos;
            end
            if (i_cmd.rot_wr) begin
                r_m <= r_m + IW'(1);
            end
            if (i_cmd.pos_dec) begin
                r_pos <= r_pos - IW'(1);
            end
            if (i_cmd.init_step || i_cmd.emit_out) begin
                r_k <= r_k + IW'(1);
            end
            if (i_cmd.emit_start) begin
                r_k <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit_out || i_cmd.emit_empty || i_cmd.emit_exh) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            r_out_pos   <= POS_W'(r_k);
            r_out_val   <= ELEM_VAL_W'(pool_rd);
            r_out_pidx  <= PIDX_W'(idx_rd);
            r_out_last  <= o_status.k_last;
            r_out_exh   <= 1'b0;
            r_out_empty <= 1'b0;
        end else if (i_cmd.emit_empty || i_cmd.emit_exh) begin
            r_out_pos   <= '0;
            r_out_val   <= '0;
            r_out_pidx  <= '0;
            r_out_last  <= 1'b1;
            r_out_exh   <= i_cmd.emit_exh;
            r_out_empty <= i_cmd.emit_empty;
        end
    end

    always_comb begin
        o_status.finished  = r_finished;
        o_status.r_zero    = (r_run_r == '0);
        o_status.dec_zero  = (cnt_dec == '0);
        o_status.m_end     = ((CW'(r_m) + CW'(1)) >= r_run_n);
        o_status.i_zero    = (r_pos == '0);
        o_status.init_last = ((CW'(r_k) + CW'(1)) == r_run_n);
        o_status.k_last    = ((CW'(r_k) + CW'(1)) == r_run_r);
        o_status.out_free  = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_position    = r_out_pos;
    assign o_value       = r_out_val;
    assign o_pool_index  = r_out_pidx;
    assign o_last        = r_out_last;
    assign o_exhausted   = r_out_exh;
    assign o_empty_tuple = r_out_empty;

endmodule

// ===== hw/rtl/partial_permutation_generator.sv =====
// load and ignored beats leave the block idle; begin fills the index and counter rams
// first; each result beat: index ram read, pool ram read, output register; advance: a
// start step, a read and a check per counter, a read and a write per index moved,
// a last read and an end step per rotate, both swap writes, all bound by the single
// write port of the index ram; one item at a time; reset is synchronous active low:
// generator exhausted, registers zero, output empty, no clearing pass over the rams
// ----------------------------------------------------------------------------
// partial_permutation_generator
// Enumerates ordered r-element arrangements of an n-element pool with the
// cycles-counter method; APB register port for pool size and tuple length.
// ----------------------------------------------------------------------------
module partial_permutation_generator #(
    parameter int MAX_POOL    = ppg_pkg::DEF_MAX_POOL,
    parameter int VALUE_WIDTH = ppg_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ppg_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // elem_index, elem_value, pad
    input  logic [ppg_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ppg_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // position, value, pool_index
    output logic [ppg_pkg::M_TUSER_W-1:0]   m_axis_tuser,  // exhausted, empty_tuple
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppg_pkg::APB_AW-1:0]      paddr,
    input  logic [ppg_pkg::APB_DW-1:0]      pwdata,
    output logic [ppg_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    import ppg_pkg::*;

    logic [CFG_W-1:0]      r_pool_size;
    logic [CFG_W-1:0]      r_tuple_len;
    logic                  cfg_wr;
    t_cmd                  cmd;
    t_status               status;
    logic [POS_W-1:0]      out_position;
    logic [ELEM_VAL_W-1:0] out_value;
    logic [PIDX_W-1:0]     out_pool_index;
    logic                  out_exhausted;
    logic                  out_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= '0;
            r_tuple_len <= '0;
        end else if (cfg_wr) begin
            case (paddr[APB_AW-1:2])
                REG_POOL_SIZE: r_pool_size <= pwdata[CFG_W-1:0];
                REG_TUPLE_LEN: r_tuple_len <= pwdata[CFG_W-1:0];
                default: r_pool_size <= r_pool_size;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_POOL_SIZE: prdata = APB_DW'(r_pool_size);
            REG_TUPLE_LEN: prdata = APB_DW'(r_tuple_len);
            default:       prdata = '0;
        endcase
    end

    ppg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ppg_dp #(
        .MAX_POOL    (MAX_POOL),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_elem_index    (s_axis_tdata[ELEM_IDX_W-1:0]),
        .i_elem_value    (s_axis_tdata[ELEM_IDX_W+ELEM_VAL_W-1:ELEM_IDX_W]),
        .i_cfg_pool_size (r_pool_size),
        .i_cfg_tuple_len (r_tuple_len),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_out_valid     (m_axis_tvalid),
        .o_position      (out_position),
        .o_value         (out_value),
        .o_pool_index    (out_pool_index),
        .o_last          (m_axis_tlast),
        .o_exhausted     (out_exhausted),
        .o_empty_tuple   (out_empty)
    );

    assign m_axis_tdata = {out_pool_index, out_value, out_position};
    assign m_axis_tuser = {out_empty, out_exhausted};

endmodule

// ===== hw/rtl/ppg_checker.sv =====
// ----------------------------------------------------------------------------
// ppg_checker
// Port-level checks of the partial permutation generator, bound to the top.
// ----------------------------------------------------------------------------
module ppg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ppg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic [ppg_pkg::MODE_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ppg_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic [ppg_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    input logic                            m_axis_tlast,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [ppg_pkg::APB_AW-1:0]      paddr,
    input logic [ppg_pkg::APB_DW-1:0]      pwdata,
    input logic [ppg_pkg::APB_DW-1:0]      prdata,
    input logic                            pready
);

    import ppg_pkg::*;

    // result beat held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // exhausted beat closes the run with all fields clear
    a_exh_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0]
        |-> m_axis_tlast && (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("malformed exhausted beat");

    // empty tuple is a single closing beat with all fields clear
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed empty tuple beat");

    // begin or advance keeps the input side closed while it runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tuser == MODE_BEGIN || s_axis_tuser == MODE_ADVANCE)
        |=> !s_axis_tready)
        else $error("input accepted during a run");

endmodule

bind partial_permutation_generator ppg_checker u_ppg_checker (.*);

// ===== dv/ppg_arrangement_checker.sv =====
// ----------------------------------------------------------------------------
// ppg_arrangement_checker
// Watches the item, result and register channels of the partial permutation
// generator. It keeps its own copy of the pool, the index order, the
// countdowns and the registers, and from each accepted item works out the
// result beats to come. Each result beat is compared with the oldest
// expected one, and register reads are compared with the written values.
// ----------------------------------------------------------------------------
module ppg_arrangement_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [ppg_pkg::S_TDATA_W-1:0] s_axis_tdata,  // elem_index, elem_value, pad
    input  logic [ppg_pkg::MODE_W-1:0]    s_axis_tuser,  // mode
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [ppg_pkg::M_TDATA_W-1:0] m_axis_tdata,  // position, value, pool_index
    input  logic [ppg_pkg::M_TUSER_W-1:0] m_axis_tuser,  // exhausted, empty_tuple
    input  logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppg_pkg::APB_AW-1:0]    paddr,
    input  logic [ppg_pkg::APB_DW-1:0]    pwdata,
    input  logic [ppg_pkg::APB_DW-1:0]    prdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ppg_pkg::*;

    localparam int POOL_DEPTH = DEF_MAX_POOL;

    typedef struct packed {
        logic [POS_W-1:0]      position;
        logic [ELEM_VAL_W-1:0] value;
        logic [PIDX_W-1:0]     pool_index;
        logic                  last;
        logic                  exhausted;
        logic                  empty_tuple;
    } elem_beat_t;

    logic [ELEM_VAL_W-1:0] pool_vals [POOL_DEPTH];
    logic [PIDX_W-1:0]     order [POOL_DEPTH];
    int                    countdown [POOL_DEPTH];
    logic                  done;
    logic [CFG_W-1:0]      cfg_pool;
    logic [CFG_W-1:0]      cfg_len;
    int                    run_pool;
    int                    run_len;
    elem_beat_t            awaited [$];
    int                    fail_count;
    int                    pending_n;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    function automatic void report(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", what);
        end
    endfunction

    function automatic void push_beat(int pos, logic [ELEM_VAL_W-1:0] val, int pidx,
                                      bit lst, bit exh, bit emp);
        elem_beat_t b;
        b.position    = POS_W'(pos);
        b.value       = val;
        b.pool_index  = PIDX_W'(pidx);
        b.last        = lst;
        b.exhausted   = exh;
        b.empty_tuple = emp;
        awaited = {awaited, b};
    endfunction

    function automatic void push_arrangement();
        int k;
        if (run_len == 0) begin
            push_beat(0, '0, 0, 1'b1, 1'b0, 1'b1);
        end else begin
            for (k = 0; k < run_len; k++) begin
                push_beat(k, pool_vals[order[k]], int'(order[k]), k + 1 == run_len, 1'b0, 1'b0);
            end
        end
    endfunction

    function automatic void start_run();
        int i;
        run_pool = (cfg_pool > POOL_DEPTH) ? POOL_DEPTH : int'(cfg_pool);
        run_len  = int'(cfg_len);
        for (i = 0; i < POOL_DEPTH; i++) begin
            order[i]     = PIDX_W'(i);
            countdown[i] = 0;
        end
        done = run_len > run_pool;
        if (!done) begin
            for (i = 0; i < run_len; i++) begin
                countdown[i] = run_pool - i;
            end
        end
    endfunction

    // walk the countdowns from the last position back: swap on nonzero, rotate on zero
    function automatic bit next_arrangement();
        int j;
        int i;
        int m;
        int other;
        logic [PIDX_W-1:0] head;
        if (run_len == 0) begin
            return 1'b0;
        end
        for (j = run_len; j > 0; j--) begin
            i = j - 1;
            countdown[i] = countdown[i] - 1;
            if (countdown[i] == 0) begin
                head = order[i];
                for (m = i; m + 1 < run_pool; m++) begin
                    order[m] = order[m + 1];
                end
                order[run_pool - 1] = head;
                countdown[i] = run_pool - i;
            end else begin
                other        = run_pool - countdown[i];
                head         = order[i];
                order[i]     = order[other];
                order[other] = head;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void apply_item(logic [MODE_W-1:0] mode, logic [ELEM_IDX_W-1:0] idx,
                                       logic [ELEM_VAL_W-1:0] val);
        case (mode)
            MODE_LOAD: begin
                pool_vals[idx] = val;
            end
            MODE_BEGIN: begin
                start_run();
                if (done) begin
                    push_beat(0, '0, 0, 1'b1, 1'b1, 1'b0);
                end else begin
                    push_arrangement();
                end
            end
            MODE_ADVANCE: begin
                if (done) begin
                    push_beat(0, '0, 0, 1'b1, 1'b1, 1'b0);
                end else if (!next_arrangement()) begin
                    done = 1'b1;
                    push_beat(0, '0, 0, 1'b1, 1'b1, 1'b0);
                end else begin
                    push_arrangement();
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        elem_beat_t got;
        elem_beat_t want;
        logic [CFG_W-1:0] reg_val;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_DEPTH; i++) begin
                pool_vals[i] = '0;
                order[i]     = PIDX_W'(i);
                countdown[i] = 0;
            end
            done     = 1'b1;
            cfg_pool = '0;
            cfg_len  = '0;
            run_pool = 0;
            run_len  = 0;
            awaited.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pready === 1'b1) begin
                if (paddr == APB_AW'(4 * int'(REG_POOL_SIZE)) ||
                    paddr == APB_AW'(4 * int'(REG_TUPLE_LEN))) begin
                    if (pwrite) begin
                        if (paddr == APB_AW'(4 * int'(REG_POOL_SIZE))) begin
                            cfg_pool = pwdata[CFG_W-1:0];
                        end else begin
                            cfg_len = pwdata[CFG_W-1:0];
                        end
                    end else begin
                        reg_val = (paddr == APB_AW'(4 * int'(REG_POOL_SIZE))) ? cfg_pool : cfg_len;
                        if (prdata !== APB_DW'(reg_val)) begin
                            report($sformatf("register read at %0d: expected %h got %h",
                                             paddr, APB_DW'(reg_val), prdata));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                apply_item(s_axis_tuser, s_axis_tdata[ELEM_IDX_W-1:0],
                           s_axis_tdata[ELEM_IDX_W +: ELEM_VAL_W]);
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.position    = m_axis_tdata[POS_W-1:0];
                got.value       = m_axis_tdata[POS_W +: ELEM_VAL_W];
                got.pool_index  = m_axis_tdata[POS_W + ELEM_VAL_W +: PIDX_W];
                got.last        = m_axis_tlast;
                got.exhausted   = m_axis_tuser[0];
                got.empty_tuple = m_axis_tuser[1];
                if (awaited.size() == 0) begin
                    report($sformatf("unexpected result beat: pos %0d val %h idx %0d",
                                     got.position, got.value, got.pool_index));
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        report($sformatf({"result mismatch: expected pos %0d val %h idx %0d ",
                                          "last %b exh %b empty %b, got pos %0d val %h ",
                                          "idx %0d last %b exh %b empty %b"},
                                         want.position, want.value, want.pool_index,
                                         want.last, want.exhausted, want.empty_tuple,
                                         got.position, got.value, got.pool_index,
                                         got.last, got.exhausted, got.empty_tuple));
                    end
                end
            end
        end
        pending_n = awaited.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the partial permutation generator: pool loads, begin and
// advance items under several pool sizes and tuple lengths, written over the
// register port while the block is idle. The sender works in bursts, the
// receiver stalls on its own pattern with one long hold-off, and the
// arrangement checker beside the block judges every result beat.
// ----------------------------------------------------------------------------
module tb;
    import ppg_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;  // elem_index, elem_value, pad
    logic [MODE_W-1:0]     s_axis_tuser;  // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;  // position, value, pool_index
    logic [M_TUSER_W-1:0]  m_axis_tuser;  // exhausted, empty_tuple
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int fail_total;
    int pending_total;
    int items_sent;
    int burst_left;
    bit hold_req;

    partial_permutation_generator dut (.*);

    ppg_arrangement_checker watch (
        .o_fail_count (fail_total),
        .o_pending    (pending_total),
        .*
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * 2_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int pattern;
        int span;
        bit held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        forever begin
            pattern = $urandom_range(0, 2);
            span    = $urandom_range(20, 150);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req && !held) begin
                    held = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (400) @(negedge i_clk);
                end
                case (pattern)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(logic [MODE_W-1:0] mode, logic [ELEM_IDX_W-1:0] idx,
                             logic [ELEM_VAL_W-1:0] val);
        @(negedge i_clk);
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, val, idx};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (mode != MODE_UNUSED) begin
            items_sent++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // stop offering and wait for every expected beat, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_total != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic apb_access(logic wr, t_reg which, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'(4 * int'(which));
        pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] n, logic [CFG_W-1:0] r);
        drain();
        apb_access(1'b1, REG_POOL_SIZE, n);
        apb_access(1'b1, REG_TUPLE_LEN, r);
        apb_access(1'b0, REG_POOL_SIZE, '0);
        apb_access(1'b0, REG_TUPLE_LEN, '0);
    endtask

    initial begin
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] r;
        int steps;
        int roll;
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_LOAD;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        burst_left    = $urandom_range(1, 24);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // advance before any begin, empty tuple from reset registers, ignored mode
        send_item(MODE_ADVANCE, '0, '0);
        send_item(MODE_BEGIN, 4'hF, 32'hFFFF_FFFF);
        send_item(MODE_ADVANCE, '0, '0);
        send_item(MODE_UNUSED, 4'($urandom), $urandom);
        for (k = 0; k < DEF_MAX_POOL; k++) begin
            send_item(MODE_LOAD, 4'(k),
                      (k == 0) ? 32'h0 : (k == DEF_MAX_POOL - 1) ? 32'hFFFF_FFFF : $urandom);
        end
        // oversized pool saturates, tuple still longer than pool
        set_config(5'd31, 5'd17);
        send_item(MODE_BEGIN, '0, '0);
        // full walk of a two-element pool, then advance after exhaustion
        set_config(5'd2, 5'd2);
        send_item(MODE_BEGIN, '0, '0);
        repeat (3) send_item(MODE_ADVANCE, '0, '0);
        set_config(5'd16, 5'd16);
        send_item(MODE_BEGIN, '0, '0);
        send_item(MODE_ADVANCE, '0, '0);

        // long receiver hold-off while items keep coming
        set_config(5'd16, 5'd16);
        hold_req   = 1'b1;
        burst_left = 30;
        send_item(MODE_BEGIN, '0, '0);
        repeat (8) send_item(MODE_ADVANCE, 4'($urandom), $urandom);

        while (items_sent < 200) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                n = 5'($urandom_range(0, 5));
                r = 5'($urandom_range(0, int'(n) + 1));
            end else if (roll < 8) begin
                n = 5'($urandom_range(6, 16));
                r = 5'($urandom_range(0, int'(n)));
            end else if (roll == 8) begin
                n = 5'd16;
                r = 5'($urandom_range(12, 16));
            end else begin
                n = 5'($urandom_range(17, 31));
                r = 5'($urandom_range(0, 31));
            end
            set_config(n, r);
            send_item(MODE_BEGIN, 4'($urandom), $urandom);
            steps = $urandom_range(1, 20);
            repeat (steps) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    send_item(MODE_LOAD, 4'($urandom), $urandom);
                end else if (roll == 1) begin
                    send_item(MODE_UNUSED, 4'($urandom), $urandom);
                end else if (roll == 2) begin
                    send_item(MODE_BEGIN, 4'($urandom), $urandom);
                end else if (roll == 3) begin
                    // register change mid-run, seen only at the next begin
                    set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
                end else begin
                    send_item(MODE_ADVANCE, 4'($urandom), $urandom);
                end
            end
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (fail_total == 0 && pending_total == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
